[sv/rrts_pkg.sv]
package rrts_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELAY  = 3'd1,
    OP_FINISH = 3'd2,
    OP_PICK   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_FULL       = 3'd1,
    RS_NO_CURRENT = 3'd2,
    RS_NONE_READY = 3'd3,
    RS_NO_ACTIVE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SS_UNUSED   = 2'd0,
    SS_READY    = 2'd1,
    SS_BLOCKED  = 2'd2,
    SS_FINISHED = 2'd3
  } slot_state_e;

  typedef enum logic [3:0] {
    FSM_IDLE  = 4'b0001,
    FSM_CHECK = 4'b0010,
    FSM_SCAN  = 4'b0100,
    FSM_DONE  = 4'b1000
  } fsm_e;

  // Write strobes from the sequencer to the slot store.
  typedef struct packed {
    logic clear;
    logic st_we;
    logic wake_we;
  } store_ctrl_t;

  localparam int TimeW = 32;

endpackage

[sv/rrts_alu.sv]
module rrts_alu (
  input  logic [rrts_pkg::TimeW-1:0] a_i,
  input  logic [rrts_pkg::TimeW-1:0] b_i,
  input  logic                       sub_i,
  output logic [rrts_pkg::TimeW-1:0] sum_o,
  output logic                       carry_o
);
  import rrts_pkg::*;

  logic [TimeW:0] sum;
  logic [TimeW-1:0] b_op;

  // In subtract mode a set carry means no borrow, that is a >= b.
  assign b_op    = sub_i ? ~b_i : b_i;
  assign sum     = {1'b0, a_i} + {1'b0, b_op} + {{TimeW{1'b0}}, sub_i};
  assign sum_o   = sum[TimeW-1:0];
  assign carry_o = sum[TimeW];

endmodule

[sv/rrts_store.sv]
module rrts_store #(
  parameter int  NUM_SLOTS = 10,
  localparam int IW        = $clog2(NUM_SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rrts_pkg::store_ctrl_t       ctrl_i,
  input  logic [IW-1:0]               st_idx_i,
  input  rrts_pkg::slot_state_e       st_wr_val_i,
  output rrts_pkg::slot_state_e       st_rd_o,
  input  logic [rrts_pkg::TimeW-1:0]  wake_wr_data_i,
  input  logic [IW-1:0]               wake_rd_idx_i,
  output logic [rrts_pkg::TimeW-1:0]  wake_rd_o
);
  import rrts_pkg::*;

  slot_state_e          st_q [NUM_SLOTS];
  logic [TimeW-1:0]     wake_mem [NUM_SLOTS];
  logic [TimeW-1:0]     wake_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= SS_UNUSED;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= SS_UNUSED;
    end else if (ctrl_i.st_we) begin
      st_q[st_idx_i] <= st_wr_val_i;
    end
  end

  assign st_rd_o = st_q[st_idx_i];

  // Wake times are only read for blocked slots, which a delay has always
  // written, so the memory needs no clearing.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wake_we) begin
      wake_mem[st_idx_i] <= wake_wr_data_i;
    end
    wake_rd_q <= wake_mem[wake_rd_idx_i];
  end

  assign wake_rd_o = wake_rd_q;

endmodule

[sv/round_robin_task_scheduler_core.sv]
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o | operation_i, now_ms_i, delay_ms_i
// out      | output    | out_valid_o/ out_stall_i| status_o, slot_o, active_count_o
//
// Create and pick scan one slot per cycle through the shared slot store and
// adder; delay and finish check and update the current slot once, while clear and
// the early refusals go straight to the result stage.
// The input is stalled while an item is in work; a result waiting in the
// output register does not block the next item until that item is done.
// Reset (and the clear operation) marks all slots unused with no current task.
module round_robin_task_scheduler_core #(
  parameter int NUM_SLOTS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] now_ms_i,
  input  logic [30:0] delay_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [3:0]  active_count_o
);
  import rrts_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_SLOTS - 1);

  fsm_e             state_q, state_d;
  op_e              op_q, op_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [30:0]      dly_q, dly_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    cur_q, cur_d;
  logic             curv_q, curv_d;
  logic [LW-1:0]    live_q, live_d;
  status_e          res_status_q, res_status_d;
  logic [IW-1:0]    res_slot_q, res_slot_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [3:0]       out_slot_q, out_slot_d;
  logic [3:0]       out_live_q, out_live_d;

  store_ctrl_t      ctrl;
  slot_state_e      st_wr_val;
  slot_state_e      st_rd;
  logic [TimeW-1:0] wake_rd;
  logic [TimeW-1:0] alu_b;
  logic [TimeW-1:0] alu_sum;
  logic             alu_carry;
  logic             alu_sub;
  logic [TimeW-1:0] wake_sat;
  logic [IW-1:0]    idx_next;
  logic [IW-1:0]    cur_next;
  logic             hit;
  logic             due;
  logic [IW+3:0]    slot_ext;
  logic [LW+3:0]    live_ext;

  rrts_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .st_idx_i       (idx_q),
    .st_wr_val_i    (st_wr_val),
    .st_rd_o        (st_rd),
    .wake_wr_data_i (wake_sat),
    .wake_rd_idx_i  (idx_d),
    .wake_rd_o      (wake_rd)
  );

  // Adds the delay during a delay, compares now against the wake time in a scan.
  assign alu_sub = (state_q == FSM_SCAN);
  assign alu_b   = alu_sub ? wake_rd : {1'b0, dly_q};

  rrts_alu u_alu (
    .a_i     (now_q),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign wake_sat = alu_carry ? {TimeW{1'b1}} : alu_sum;
  assign idx_next = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign cur_next = (cur_q == LastIdx) ? '0 : cur_q + 1'b1;
  assign due      = (st_rd == SS_BLOCKED) && alu_carry;

  assign in_stall_o = (state_q != FSM_IDLE);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    now_d        = now_q;
    dly_d        = dly_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    curv_d       = curv_q;
    live_d       = live_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_live_d   = out_live_q;
    ctrl         = '0;
    st_wr_val    = SS_READY;
    hit          = 1'b0;
    slot_ext     = '0;
    live_ext     = '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(operation_i);
          now_d        = now_ms_i;
          dly_d        = delay_ms_i;
          res_slot_d   = '0;
          res_status_d = RS_OK;
          cnt_d        = '0;
          state_d      = FSM_DONE;
          unique case (op_e'(operation_i))
            OP_CREATE: begin
              if (live_q >= LW'(NUM_SLOTS)) begin
                res_status_d = RS_FULL;
              end else begin
                idx_d   = '0;
                state_d = FSM_SCAN;
              end
            end
            OP_DELAY, OP_FINISH: begin
              if (!curv_q) begin
                res_status_d = RS_NO_CURRENT;
              end else begin
                idx_d   = cur_q;
                state_d = FSM_CHECK;
              end
            end
            OP_PICK: begin
              if (live_q == '0) begin
                res_status_d = RS_NO_ACTIVE;
              end else begin
                idx_d   = curv_q ? cur_next : '0;
                state_d = FSM_SCAN;
              end
            end
            OP_CLEAR: begin
              ctrl.clear = 1'b1;
              live_d     = '0;
              cur_d      = '0;
              curv_d     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      FSM_CHECK: begin
        state_d = FSM_DONE;
        if (st_rd == SS_READY) begin
          res_status_d = RS_OK;
          res_slot_d   = idx_q;
          ctrl.st_we   = 1'b1;
          if (op_q == OP_DELAY) begin
            st_wr_val    = SS_BLOCKED;
            ctrl.wake_we = 1'b1;
          end else begin
            st_wr_val = SS_FINISHED;
            if (live_q != '0) live_d = live_q - 1'b1;
          end
        end else begin
          res_status_d = RS_NO_CURRENT;
        end
      end

      FSM_SCAN: begin
        if (op_q == OP_CREATE) begin
          hit        = (st_rd == SS_UNUSED) || (st_rd == SS_FINISHED);
          ctrl.st_we = hit;
          if (hit) live_d = live_q + 1'b1;
        end else begin
          // A due blocked slot is woken and selected, just like a ready one.
          hit        = (st_rd == SS_READY) || due;
          ctrl.st_we = due;
          if (hit) begin
            cur_d  = idx_q;
            curv_d = 1'b1;
          end
        end
        if (hit) begin
          res_status_d = RS_OK;
          res_slot_d   = idx_q;
          state_d      = FSM_DONE;
        end else if (cnt_q == LastIdx) begin
          res_status_d = (op_q == OP_CREATE) ? RS_FULL : RS_NONE_READY;
          state_d      = FSM_DONE;
        end else begin
          idx_d = idx_next;
          cnt_d = cnt_q + 1'b1;
        end
      end

      FSM_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          slot_ext     = {4'b0, res_slot_q};
          live_ext     = {4'b0, live_q};
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = slot_ext[3:0];
          out_live_d   = live_ext[3:0];
          state_d      = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      curv_q      <= 1'b0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      curv_q      <= curv_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    now_q        <= now_d;
    dly_q        <= dly_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_live_q   <= out_live_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_o         = out_slot_q;
  assign active_count_o = out_live_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state is not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni) live_q <= LW'(NUM_SLOTS))
    else $error("live task count exceeds the number of slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("a second item was taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != RS_OK) |-> (slot_o == 4'd0))
    else $error("a refused item reports a non-zero slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DONE) && (res_status_q == RS_OK) && (op_q == OP_PICK)
      |-> curv_q && (cur_q == res_slot_q))
    else $error("picked slot does not match the current slot");
`endif

endmodule

[tb/round_robin_task_scheduler_core_tb.sv]
module round_robin_task_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int NumSlots = 10;
  localparam int LongHoldCycles = 200;
  localparam int DrainCycles = 4 * NumSlots;
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast = 3'd7;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic [3:0] live;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [31:0] now_ms_i;
  logic [30:0] delay_ms_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [3:0]  active_count_o;

  // Predicted scheduler state.
  slot_state_e slot_st [NumSlots];
  logic [31:0] wake_at [NumSlots];
  int          cur_slot;
  bit          cur_valid;
  int          live_cnt;

  sched_result_t awaited_results[$];
  logic [31:0]   clock_ms;
  bit            tx_idle_en;
  bit            rx_idle_en;
  bit            hold_off_req;
  int            hold_off_done;
  int            mismatch_cnt;
  int            checked_cnt;
  int            op_seen [8];
  int            status_seen [5];

  round_robin_task_scheduler_core #(
    .NUM_SLOTS(NumSlots)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .now_ms_i      (now_ms_i),
    .delay_ms_i    (delay_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .active_count_o(active_count_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void sched_reset();
    for (int i = 0; i < NumSlots; i++) begin
      slot_st[i] = SS_UNUSED;
      wake_at[i] = '0;
    end
    cur_slot  = 0;
    cur_valid = 1'b0;
    live_cnt  = 0;
  endfunction

  function automatic sched_result_t sched_predict(input logic [2:0] op,
                                                  input logic [31:0] now,
                                                  input logic [30:0] dly);
    sched_result_t res;
    logic [32:0]   wake_sum;
    int            idx;
    bit            found;
    bit            running;
    res.status = RS_OK;
    res.slot   = '0;
    found      = 1'b0;
    // Only a current task that is still ready may be delayed or finished.
    running    = cur_valid && slot_st[cur_slot] == SS_READY;
    case (op)
      OP_CREATE: begin
        res.status = RS_FULL;
        if (live_cnt < NumSlots) begin
          for (int i = 0; i < NumSlots && !found; i++) begin
            if (slot_st[i] == SS_UNUSED || slot_st[i] == SS_FINISHED) begin
              found      = 1'b1;
              slot_st[i] = SS_READY;
              wake_at[i] = '0;
              live_cnt++;
              res.status = RS_OK;
              res.slot   = 4'(i);
            end
          end
        end
      end
      OP_DELAY: begin
        if (!running) begin
          res.status = RS_NO_CURRENT;
        end else begin
          wake_sum = {1'b0, now} + {2'b00, dly};
          slot_st[cur_slot] = SS_BLOCKED;
          wake_at[cur_slot] = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
          res.slot = 4'(cur_slot);
        end
      end
      OP_FINISH: begin
        if (!running) begin
          res.status = RS_NO_CURRENT;
        end else begin
          slot_st[cur_slot] = SS_FINISHED;
          if (live_cnt > 0) live_cnt--;
          res.slot = 4'(cur_slot);
        end
      end
      OP_PICK: begin
        if (live_cnt == 0) begin
          res.status = RS_NO_ACTIVE;
        end else begin
          res.status = RS_NONE_READY;
          idx = cur_valid ? cur_slot + 1 : 0;
          // A due sleeper is woken on the way and then chosen like a ready slot.
          for (int i = 0; i < NumSlots && !found; i++) begin
            if (idx >= NumSlots) idx -= NumSlots;
            if (slot_st[idx] == SS_BLOCKED && now >= wake_at[idx]) slot_st[idx] = SS_READY;
            if (slot_st[idx] == SS_READY) begin
              found      = 1'b1;
              cur_slot   = idx;
              cur_valid  = 1'b1;
              res.status = RS_OK;
              res.slot   = 4'(idx);
            end
            idx++;
          end
        end
      end
      OP_CLEAR: begin
        sched_reset();
      end
      default: begin
      end
    endcase
    res.live = 4'(live_cnt);
    return res;
  endfunction

  // Offers one item and returns at the edge on which it is taken.
  task automatic send_request(input logic [2:0] op, input logic [31:0] now,
                              input logic [30:0] dly);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    now_ms_i    <= now;
    delay_ms_i  <= dly;
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(sched_predict(op, now, dly));
    op_seen[op]++;
  endtask

  task automatic send_random_request();
    int unsigned roll;
    logic [2:0]  op;
    logic [31:0] now;
    logic [30:0] dly;
    roll = $urandom_range(0, 99);
    if (roll < 24) op = OP_CREATE;
    else if (roll < 59) op = OP_PICK;
    else if (roll < 79) op = OP_DELAY;
    else if (roll < 93) op = OP_FINISH;
    else if (roll < 95) op = OP_CLEAR;
    else op = 3'($urandom_range(OpSpareFirst, OpSpareLast));
    // Time mostly creeps forward so that short delays expire; now and then it
    // jumps, or sits just below the top of the range.
    roll = $urandom_range(0, 99);
    if (roll < 3) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 64);
    else if (roll < 6) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 20);
    now = clock_ms;
    if ($urandom_range(0, 19) == 0) now = $urandom;
    roll = $urandom_range(0, 9);
    if (roll < 7) dly = 31'($urandom_range(0, 40));
    else if (roll < 9) dly = 31'($urandom);
    else dly = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
    send_request(op, now, dly);
  endtask

  task automatic test_empty_refusals();
    send_request(OP_PICK, 32'd0, 31'd0);
    send_request(OP_DELAY, 32'd5, 31'd5);
    send_request(OP_FINISH, 32'd5, 31'd0);
  endtask

  task automatic test_fill_and_retire();
    repeat (NumSlots) send_request(OP_CREATE, 32'd0, 31'd0);
    send_request(OP_CREATE, 32'd1, 31'd0);
    send_request(OP_PICK, 32'd10, 31'd0);
    send_request(OP_DELAY, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(OP_DELAY, 32'd10, 31'd1);
    send_request(OP_PICK, 32'd10, 31'd0);
    send_request(OP_FINISH, 32'd11, 31'd0);
    send_request(OP_FINISH, 32'd11, 31'd0);
    send_request(OP_CREATE, 32'd12, 31'd0);
    send_request(OpSpareFirst, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(OpSpareLast, 32'd0, 31'd0);
    send_request(OP_CLEAR, 32'd0, 31'd0);
  endtask

  // A sleeper stays blocked one millisecond short of its wake time and is
  // woken exactly at it.
  task automatic test_wake_deadline();
    send_request(OP_CREATE, 32'd100, 31'd0);
    send_request(OP_PICK, 32'd100, 31'd0);
    send_request(OP_DELAY, 32'd100, 31'd50);
    send_request(OP_PICK, 32'd149, 31'd0);
    send_request(OP_PICK, 32'd150, 31'd0);
  endtask

  task automatic test_random_mix(input int n_items);
    repeat (n_items) send_random_request();
  endtask

  task automatic test_backpressure();
    hold_off_req <= 1'b1;
    repeat (24) send_random_request();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hold_off_done == 0) @(posedge clk_i);
    hold_off_req <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && hold_off_done == 0) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_done++;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    sched_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d slot %0d live %0d", $time, status_o,
                 slot_o, active_count_o);
        mismatch_cnt++;
      end else begin
        want = awaited_results.pop_front();
        checked_cnt++;
        status_seen[want.status]++;
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          mismatch_cnt++;
        end
        if (slot_o !== want.slot) begin
          $display("%0t: slot expected %0d, got %0d", $time, want.slot, slot_o);
          mismatch_cnt++;
        end
        if (active_count_o !== want.live) begin
          $display("%0t: active_count expected %0d, got %0d", $time, want.live,
                   active_count_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results still awaited.", awaited_results.size());
    $display("round_robin_task_scheduler_core: mismatch");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = '0;
    now_ms_i    = '0;
    delay_ms_i  = '0;
    clock_ms    = '0;
    sched_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_refusals();
    test_fill_and_retire();
    test_wake_deadline();
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    test_random_mix(700);
    test_backpressure();
    test_random_mix(250);
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_mix(300);

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent create %0d, delay %0d, finish %0d, pick %0d, clear %0d, spare codes %0d.",
             op_seen[OP_CREATE], op_seen[OP_DELAY], op_seen[OP_FINISH], op_seen[OP_PICK],
             op_seen[OP_CLEAR], op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Checked %0d results (ok %0d, full %0d, no current %0d, none ready %0d, %s%0d).",
             checked_cnt, status_seen[RS_OK], status_seen[RS_FULL],
             status_seen[RS_NO_CURRENT], status_seen[RS_NONE_READY], "no active ",
             status_seen[RS_NO_ACTIVE]);
    if (mismatch_cnt == 0 && hold_off_done > 0) begin
      $display("round_robin_task_scheduler_core: match");
    end else begin
      $display("round_robin_task_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
